// ===== rtl/core/qftv_pkg.sv =====
// ============================================================================
// qftv_pkg
// Shared types and constants for the shortest-arc quaternion datapath.
// ============================================================================
`default_nettype none

package qftv_pkg;

    // Default width of one input vector component.
    localparam int COMPONENT_WIDTH_DEF = 16;

    // Unit vectors are carried in Q.30.
    localparam int UNIT_FRAC = 30;
    localparam int NM_W      = UNIT_FRAC + 1;
    localparam int UNIT_W    = UNIT_FRAC + 2;

    // Square root and divider pipelines.
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_STEPS = 4;
    localparam int DIV_W      = 32;
    localparam int DIV_STEPS  = 4;

    // Output quaternion format, Q1.14.
    localparam int Q_FRAC = 14;
    localparam int Q_W    = 16;
    localparam logic [Q_W-1:0] Q_ONE = 16'h4000;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_ZERO_LEN     = 2'd1,
        STATUS_ANTIPARALLEL = 2'd2
    } status_t;

    // Flags that travel with one vector pair through the pipeline.
    typedef struct packed {
        logic zero_len;
        logic cross_zero;
    } vec_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/quaternion_from_two_vectors_top.sv =====
// ============================================================================
// quaternion_from_two_vectors_top
// Shortest-arc rotation quaternion between two 3D vectors, fully pipelined.
// ============================================================================
// The block takes one vector pair (u, v) per cycle and returns the unit
// quaternion, in Q1.14, that turns u onto v along the shortest arc, computed
// as normalize(1 + uh.vh, uh x vh) with uh, vh the unit vectors. On its
// way a pair passes through two square root pipelines in series (four
// result bits per stage) and two divider pipelines in series (four
// quotient bits per stage). Throughput is one pair per cycle; the whole
// pipeline holds while a result waits on the output. Zero-length inputs
// give the identity with status 1; parallel vectors give the identity
// with status 0; antiparallel vectors, or a degenerate norm, give the
// identity with status 2.
`default_nettype none

module quaternion_from_two_vectors_top #(
    parameter int COMPONENT_WIDTH = qftv_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // ux, uy, uz, vx, vy, vz from the lowest bit up, zero padded to bytes
    input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0]  s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // qw, qx, qy, qz, status from the lowest bit up, zero padded to bytes
    output logic [71:0]                             m_tdata
);

    localparam int W      = COMPONENT_WIDTH;
    localparam int UW     = qftv_pkg::UNIT_W;
    localparam int P_W    = 2 * UW;
    localparam int M_W    = P_W - 1;
    localparam int MSB_W  = $clog2(M_W);
    localparam int S_W    = qftv_pkg::UNIT_FRAC;
    localparam int SQ_W   = 2 * S_W;
    localparam int SUM_W  = qftv_pkg::SQRT_IN_W;
    localparam int DW     = qftv_pkg::DIV_W;
    localparam int QF     = qftv_pkg::Q_FRAC;
    localparam int QW     = QF + 1;
    localparam int QO_W   = qftv_pkg::Q_W;
    localparam int DD_W   = S_W + QF + 1;
    localparam int FL_W   = $bits(qftv_pkg::vec_flags_t);
    localparam int T2_W   = FL_W + 1 + 3;
    localparam int TS_W   = T2_W + 4 * S_W;

    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage T1: capture inputs, exact cross terms -------
    logic signed [W-1:0]   u_in [3];
    logic signed [W-1:0]   v_in [3];
    logic                  zl_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_in[i] = s_tdata[i*W +: W];
            v_in[i] = s_tdata[(i+3)*W +: W];
        end
        zl_in = (u_in[0] == '0 && u_in[1] == '0 && u_in[2] == '0)
             || (v_in[0] == '0 && v_in[1] == '0 && v_in[2] == '0);
    end

    logic                    vld_t1_reg;
    logic signed [W-1:0]     u_t1_reg [3];
    logic signed [W-1:0]     v_t1_reg [3];
    logic                    zl_t1_reg;
    logic signed [2*W-1:0]   xp_t1_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_t1_reg     <= u_in;
            v_t1_reg     <= v_in;
            zl_t1_reg    <= zl_in;
            xp_t1_reg[0] <= u_in[1] * v_in[2];
            xp_t1_reg[1] <= u_in[2] * v_in[1];
            xp_t1_reg[2] <= u_in[2] * v_in[0];
            xp_t1_reg[3] <= u_in[0] * v_in[2];
            xp_t1_reg[4] <= u_in[0] * v_in[1];
            xp_t1_reg[5] <= u_in[1] * v_in[0];
        end
    end

    qftv_pkg::vec_flags_t flags_t1;

    assign flags_t1.zero_len   = zl_t1_reg;
    assign flags_t1.cross_zero = (xp_t1_reg[0] == xp_t1_reg[1])
                              && (xp_t1_reg[2] == xp_t1_reg[3])
                              && (xp_t1_reg[4] == xp_t1_reg[5]);

    // ---------------- unit vectors --------------------------------------
    logic                    vld_un;
    logic signed [UW-1:0]    uh [3];
    logic signed [UW-1:0]    vh [3];
    qftv_pkg::vec_flags_t    flags_un;

    qftv_unit #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .TAG_W           (FL_W)
    ) u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_t1_reg),
        .in_u    (u_t1_reg),
        .in_v    (v_t1_reg),
        .in_tag  (flags_t1),
        .out_vld (vld_un),
        .out_uh  (uh),
        .out_vh  (vh),
        .out_tag (flags_un)
    );

    // ---------------- T2: products, T3: dot / cross ---------------------
    logic                    vld_t2_reg, vld_t3_reg, vld_t4_reg, vld_t5_reg;
    logic                    vld_t6_reg, vld_t7_reg;
    logic signed [P_W-1:0]   p_t2_reg [9];
    qftv_pkg::vec_flags_t    fl_t2_reg, fl_t3_reg, fl_t4_reg, fl_t5_reg;
    qftv_pkg::vec_flags_t    fl_t6_reg, fl_t7_reg;

    logic signed [P_W-1:0]   dot;
    logic signed [P_W-1:0]   w_raw;
    logic signed [P_W-1:0]   cr [3];

    always_comb
    begin
        dot   = p_t2_reg[0] + p_t2_reg[1] + p_t2_reg[2];
        cr[0] = p_t2_reg[3] - p_t2_reg[4];
        cr[1] = p_t2_reg[5] - p_t2_reg[6];
        cr[2] = p_t2_reg[7] - p_t2_reg[8];
        w_raw = (P_W'(1) <<< (2 * qftv_pkg::UNIT_FRAC)) + dot;
    end

    logic [M_W-1:0]          w_t3_reg;
    logic signed [P_W-1:0]   cr_t3_reg [3];
    logic                    dn_t3_reg, dn_t4_reg, dn_t5_reg, dn_t6_reg, dn_t7_reg;

    // ---------------- T4: magnitudes, T5: shift below 2^30 --------------
    logic [3:0][M_W-1:0]     m_t4_reg;
    logic [2:0]              sg_t4_reg, sg_t5_reg, sg_t6_reg, sg_t7_reg;
    logic [3:0][M_W-1:0]     m_t4_next;

    always_comb
    begin
        m_t4_next[0] = w_t3_reg;
        for (int i = 0; i < 3; i++)
        begin
            m_t4_next[i+1] = cr_t3_reg[i][P_W-1] ? M_W'(-cr_t3_reg[i])
                                                 : M_W'(cr_t3_reg[i]);
        end
    end

    logic [M_W-1:0]          m_or;
    logic [MSB_W-1:0]        m_msb;
    logic [MSB_W-1:0]        k_sh;
    logic [3:0][S_W-1:0]     s_t5_next;
    logic [M_W-1:0]          shifted;

    always_comb
    begin
        m_or  = m_t4_reg[0] | m_t4_reg[1] | m_t4_reg[2] | m_t4_reg[3];
        m_msb = '0;
        for (int b = 0; b < M_W; b++)
        begin
            if (m_or[b])
            begin
                m_msb = MSB_W'(b);
            end
        end
        k_sh    = (m_msb >= MSB_W'(S_W)) ? (m_msb - MSB_W'(S_W - 1)) : '0;
        shifted = '0;
        for (int i = 0; i < 4; i++)
        begin
            shifted      = m_t4_reg[i] >> k_sh;
            s_t5_next[i] = shifted[S_W-1:0];
        end
    end

    logic [3:0][S_W-1:0]     s_t5_reg, s_t6_reg, s_t7_reg;
    logic [3:0][SQ_W-1:0]    sq_t6_reg;
    logic [SUM_W-1:0]        sum_t7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_t1_reg <= 1'b0;
            vld_t2_reg <= 1'b0;
            vld_t3_reg <= 1'b0;
            vld_t4_reg <= 1'b0;
            vld_t5_reg <= 1'b0;
            vld_t6_reg <= 1'b0;
            vld_t7_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_t1_reg <= s_tvalid;
            vld_t2_reg <= vld_un;
            vld_t3_reg <= vld_t2_reg;
            vld_t4_reg <= vld_t3_reg;
            vld_t5_reg <= vld_t4_reg;
            vld_t6_reg <= vld_t5_reg;
            vld_t7_reg <= vld_t6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_t2_reg[0] <= uh[0] * vh[0];
            p_t2_reg[1] <= uh[1] * vh[1];
            p_t2_reg[2] <= uh[2] * vh[2];
            p_t2_reg[3] <= uh[1] * vh[2];
            p_t2_reg[4] <= uh[2] * vh[1];
            p_t2_reg[5] <= uh[2] * vh[0];
            p_t2_reg[6] <= uh[0] * vh[2];
            p_t2_reg[7] <= uh[0] * vh[1];
            p_t2_reg[8] <= uh[1] * vh[0];
            fl_t2_reg   <= flags_un;

            // The scalar part is clamped at zero.
            w_t3_reg    <= w_raw[P_W-1] ? '0 : w_raw[M_W-1:0];
            cr_t3_reg   <= cr;
            dn_t3_reg   <= dot[P_W-1];
            fl_t3_reg   <= fl_t2_reg;

            m_t4_reg    <= m_t4_next;
            sg_t4_reg   <= {cr_t3_reg[2][P_W-1], cr_t3_reg[1][P_W-1], cr_t3_reg[0][P_W-1]};
            dn_t4_reg   <= dn_t3_reg;
            fl_t4_reg   <= fl_t3_reg;

            s_t5_reg    <= s_t5_next;
            sg_t5_reg   <= sg_t4_reg;
            dn_t5_reg   <= dn_t4_reg;
            fl_t5_reg   <= fl_t4_reg;

            for (int i = 0; i < 4; i++)
            begin
                sq_t6_reg[i] <= s_t5_reg[i] * s_t5_reg[i];
            end
            s_t6_reg    <= s_t5_reg;
            sg_t6_reg   <= sg_t5_reg;
            dn_t6_reg   <= dn_t5_reg;
            fl_t6_reg   <= fl_t5_reg;

            sum_t7_reg  <= SUM_W'(sq_t6_reg[0]) + SUM_W'(sq_t6_reg[1])
                         + SUM_W'(sq_t6_reg[2]) + SUM_W'(sq_t6_reg[3]);
            s_t7_reg    <= s_t6_reg;
            sg_t7_reg   <= sg_t6_reg;
            dn_t7_reg   <= dn_t6_reg;
            fl_t7_reg   <= fl_t6_reg;
        end
    end

    // ---------------- norm ----------------------------------------------
    logic                  vld_nr;
    logic [DW-1:0]         nrm;
    logic [TS_W-1:0]       tag_nr;

    qftv_isqrt #(
        .IN_W  (SUM_W),
        .STEPS (qftv_pkg::SQRT_STEPS),
        .TAG_W (TS_W)
    ) u_sqrt_n (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_t7_reg),
        .in_x     (sum_t7_reg),
        .in_tag   ({fl_t7_reg, dn_t7_reg, sg_t7_reg, s_t7_reg}),
        .out_vld  (vld_nr),
        .out_root (nrm),
        .out_tag  (tag_nr)
    );

    // ---------------- rounded division by the norm ----------------------
    // Dividend is m * 2^14 + nrm / 2; the quotient fits in fifteen bits, so
    // the top part of the dividend already sits below the divisor.
    logic [3:0][S_W-1:0]   s_nr;
    logic [3:0][DW-1:0]    rem_q;
    logic [3:0][QW-1:0]    feed_q;
    logic [DD_W-1:0]       dd;

    assign s_nr = tag_nr[4*S_W-1:0];

    always_comb
    begin
        dd = '0;
        for (int i = 0; i < 4; i++)
        begin
            dd        = {s_nr[i], {QF{1'b0}}} + DD_W'(nrm >> 1);
            rem_q[i]  = DW'(dd[DD_W-1:QW]);
            feed_q[i] = dd[QW-1:0];
        end
    end

    logic                  vld_dq;
    logic [3:0][QW-1:0]    quo;
    logic [T2_W:0]         tag_dq;

    qftv_div #(
        .LANES (4),
        .QW    (QW),
        .DW    (DW),
        .STEPS (qftv_pkg::DIV_STEPS),
        .TAG_W (T2_W + 1)
    ) u_div_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_nr),
        .in_rem  (rem_q),
        .in_feed (feed_q),
        .in_div  (nrm),
        .in_tag  ({tag_nr[TS_W-1:4*S_W], nrm == '0}),
        .out_vld (vld_dq),
        .out_quo (quo),
        .out_tag (tag_dq)
    );

    // ---------------- output ----------------------------------------------
    qftv_pkg::vec_flags_t  fl_o;
    logic                  dn_o;
    logic [2:0]            sg_o;
    logic                  nz_o;
    logic [QO_W-1:0]       mag_o [4];
    logic [QO_W-1:0]       q_o   [4];
    qftv_pkg::status_t     st_o;
    logic                  ident_o;

    always_comb
    begin
        {fl_o, dn_o, sg_o, nz_o} = tag_dq;
        for (int i = 0; i < 4; i++)
        begin
            mag_o[i] = (QO_W'(quo[i]) > qftv_pkg::Q_ONE) ? qftv_pkg::Q_ONE : QO_W'(quo[i]);
        end
        q_o[0] = mag_o[0];
        for (int i = 1; i < 4; i++)
        begin
            q_o[i] = sg_o[i-1] ? (~mag_o[i] + 1'b1) : mag_o[i];
        end
        ident_o = 1'b1;
        if (fl_o.zero_len)
        begin
            st_o = qftv_pkg::STATUS_ZERO_LEN;
        end
        else if (fl_o.cross_zero)
        begin
            st_o = dn_o ? qftv_pkg::STATUS_ANTIPARALLEL : qftv_pkg::STATUS_OK;
        end
        else if (nz_o)
        begin
            st_o = qftv_pkg::STATUS_ANTIPARALLEL;
        end
        else
        begin
            st_o    = qftv_pkg::STATUS_OK;
            ident_o = 1'b0;
        end
    end

    logic [QO_W-1:0]       qw_reg, qx_reg, qy_reg, qz_reg;
    qftv_pkg::status_t     status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_dq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qw_reg     <= ident_o ? qftv_pkg::Q_ONE : q_o[0];
            qx_reg     <= ident_o ? '0 : q_o[1];
            qy_reg     <= ident_o ? '0 : q_o[2];
            qz_reg     <= ident_o ? '0 : q_o[3];
            status_reg <= st_o;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, status_reg, qz_reg, qy_reg, qx_reg, qw_reg};

`ifndef SYNTHESIS
    // The input side only stalls when a finished result is held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    // A zero-length pair always yields the identity.
    a_zero_len_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == qftv_pkg::STATUS_ZERO_LEN)
        |-> (qw_reg == qftv_pkg::Q_ONE && qx_reg == '0 && qy_reg == '0 && qz_reg == '0))
        else $error("zero-length result is not the identity");

    // The scalar part is never negative.
    a_scalar_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !qw_reg[QO_W-1])
        else $error("negative scalar part");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qftv_isqrt.sv =====
// ============================================================================
// qftv_isqrt
// Pipelined integer square root, floor(sqrt(x)), STEPS result bits per stage.
// ============================================================================
`default_nettype none

module qftv_isqrt #(
    parameter int IN_W  = qftv_pkg::SQRT_IN_W,
    parameter int STEPS = qftv_pkg::SQRT_STEPS,
    parameter int TAG_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [IN_W-1:0]      in_x,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_vld,
    output logic [IN_W/2-1:0]    out_root,
    output logic [TAG_W-1:0]     out_tag
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 2;
    localparam int NST   = (OUT_W + STEPS - 1) / STEPS;

    logic                 vld_reg  [NST];
    logic [IN_W-1:0]      x_reg    [NST];
    logic [RW-1:0]        rem_reg  [NST];
    logic [OUT_W-1:0]     root_reg [NST];
    logic [TAG_W-1:0]     tag_reg  [NST];

    logic                 vld_next  [NST];
    logic [IN_W-1:0]      x_next    [NST];
    logic [RW-1:0]        rem_next  [NST];
    logic [OUT_W-1:0]     root_next [NST];
    logic [TAG_W-1:0]     tag_next  [NST];

    for (genvar st = 0; st < NST; st++) begin : g_stage
        logic [IN_W-1:0]  x_in;
        logic [RW-1:0]    rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W-1:0]  x_w;
        logic [RW-1:0]    rem_w;
        logic [OUT_W-1:0] root_w;
        logic [RW-1:0]    tmp;
        logic [RW-1:0]    trial;

        if (st == 0) begin : g_first
            assign vld_next[st] = in_vld;
            assign tag_next[st] = in_tag;
            assign x_in         = in_x;
            assign rem_in       = '0;
            assign root_in      = '0;
        end else begin : g_rest
            assign vld_next[st] = vld_reg[st-1];
            assign tag_next[st] = tag_reg[st-1];
            assign x_in         = x_reg[st-1];
            assign rem_in       = rem_reg[st-1];
            assign root_in      = root_reg[st-1];
        end

        // Classic digit-by-digit root: bring down two bits, try 4*root+1.
        always_comb
        begin
            x_w    = x_in;
            rem_w  = rem_in;
            root_w = root_in;
            tmp    = '0;
            trial  = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                if (st * STEPS + j < OUT_W)
                begin
                    tmp   = {rem_w[RW-3:0], x_w[IN_W-1 -: 2]};
                    trial = {root_w, 2'b01};
                    x_w   = {x_w[IN_W-3:0], 2'b00};
                    if (tmp >= trial)
                    begin
                        rem_w  = tmp - trial;
                        root_w = {root_w[OUT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_w  = tmp;
                        root_w = {root_w[OUT_W-2:0], 1'b0};
                    end
                end
            end
        end

        assign x_next[st]    = x_w;
        assign rem_next[st]  = rem_w;
        assign root_next[st] = root_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int st = 0; st < NST; st++)
            begin
                vld_reg[st] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int st = 0; st < NST; st++)
            begin
                vld_reg[st] <= vld_next[st];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int st = 0; st < NST; st++)
            begin
                x_reg[st]    <= x_next[st];
                rem_reg[st]  <= rem_next[st];
                root_reg[st] <= root_next[st];
                tag_reg[st]  <= tag_next[st];
            end
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_root = root_reg[NST-1];
    assign out_tag  = tag_reg[NST-1];

endmodule

`default_nettype wire

// ===== rtl/core/qftv_div.sv =====
// ============================================================================
// qftv_div
// Pipelined restoring divider, several lanes sharing one divisor.
// ============================================================================
`default_nettype none

module qftv_div #(
    parameter int LANES = 3,
    parameter int QW    = qftv_pkg::NM_W,
    parameter int DW    = qftv_pkg::DIV_W,
    parameter int STEPS = qftv_pkg::DIV_STEPS,
    parameter int TAG_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [LANES-1:0][DW-1:0]     in_rem,   // partial remainder, below in_div
    input  logic [LANES-1:0][QW-1:0]     in_feed,  // dividend bits still to bring down
    input  logic [DW-1:0]                in_div,
    input  logic [TAG_W-1:0]             in_tag,
    output logic                         out_vld,
    output logic [LANES-1:0][QW-1:0]     out_quo,
    output logic [TAG_W-1:0]             out_tag
);

    localparam int NST = (QW + STEPS - 1) / STEPS;

    logic                     vld_reg  [NST];
    logic [LANES-1:0][DW-1:0] rem_reg  [NST];
    logic [LANES-1:0][QW-1:0] feed_reg [NST];
    logic [LANES-1:0][QW-1:0] quo_reg  [NST];
    logic [DW-1:0]            div_reg  [NST];
    logic [TAG_W-1:0]         tag_reg  [NST];

    logic                     vld_next  [NST];
    logic [LANES-1:0][DW-1:0] rem_next  [NST];
    logic [LANES-1:0][QW-1:0] feed_next [NST];
    logic [LANES-1:0][QW-1:0] quo_next  [NST];
    logic [DW-1:0]            div_next  [NST];
    logic [TAG_W-1:0]         tag_next  [NST];

    for (genvar st = 0; st < NST; st++) begin : g_stage
        logic [LANES-1:0][DW-1:0] rem_in;
        logic [LANES-1:0][QW-1:0] feed_in;
        logic [LANES-1:0][QW-1:0] quo_in;
        logic [LANES-1:0][DW-1:0] rem_w;
        logic [LANES-1:0][QW-1:0] feed_w;
        logic [LANES-1:0][QW-1:0] quo_w;
        logic [DW:0]              tmp;

        if (st == 0) begin : g_first
            assign vld_next[st] = in_vld;
            assign tag_next[st] = in_tag;
            assign div_next[st] = in_div;
            assign rem_in       = in_rem;
            assign feed_in      = in_feed;
            assign quo_in       = '0;
        end else begin : g_rest
            assign vld_next[st] = vld_reg[st-1];
            assign tag_next[st] = tag_reg[st-1];
            assign div_next[st] = div_reg[st-1];
            assign rem_in       = rem_reg[st-1];
            assign feed_in      = feed_reg[st-1];
            assign quo_in       = quo_reg[st-1];
        end

        always_comb
        begin
            rem_w  = rem_in;
            feed_w = feed_in;
            quo_w  = quo_in;
            tmp    = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                if (st * STEPS + j < QW)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        tmp       = {rem_w[l], feed_w[l][QW-1]};
                        feed_w[l] = {feed_w[l][QW-2:0], 1'b0};
                        if (tmp >= {1'b0, div_next[st]})
                        begin
                            tmp      = tmp - {1'b0, div_next[st]};
                            quo_w[l] = {quo_w[l][QW-2:0], 1'b1};
                        end
                        else
                        begin
                            quo_w[l] = {quo_w[l][QW-2:0], 1'b0};
                        end
                        rem_w[l] = tmp[DW-1:0];
                    end
                end
            end
        end

        assign rem_next[st]  = rem_w;
        assign feed_next[st] = feed_w;
        assign quo_next[st]  = quo_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int st = 0; st < NST; st++)
            begin
                vld_reg[st] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int st = 0; st < NST; st++)
            begin
                vld_reg[st] <= vld_next[st];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int st = 0; st < NST; st++)
            begin
                rem_reg[st]  <= rem_next[st];
                feed_reg[st] <= feed_next[st];
                quo_reg[st]  <= quo_next[st];
                div_reg[st]  <= div_next[st];
                tag_reg[st]  <= tag_next[st];
            end
        end
    end

    assign out_vld = vld_reg[NST-1];
    assign out_quo = quo_reg[NST-1];
    assign out_tag = tag_reg[NST-1];

endmodule

`default_nettype wire

// ===== rtl/core/qftv_unit.sv =====
// ============================================================================
// qftv_unit
// Scales both input vectors to unit length in Q.30: block normalize,
// sum of squares, square root and division per component.
// ============================================================================
`default_nettype none

module qftv_unit #(
    parameter int COMPONENT_WIDTH = qftv_pkg::COMPONENT_WIDTH_DEF,
    parameter int TAG_W           = 2
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic signed [COMPONENT_WIDTH-1:0]      in_u [3],
    input  logic signed [COMPONENT_WIDTH-1:0]      in_v [3],
    input  logic [TAG_W-1:0]                       in_tag,
    output logic                                   out_vld,
    output logic signed [qftv_pkg::UNIT_W-1:0]     out_uh [3],
    output logic signed [qftv_pkg::UNIT_W-1:0]     out_vh [3],
    output logic [TAG_W-1:0]                       out_tag
);

    localparam int W    = COMPONENT_WIDTH;
    localparam int PW   = $clog2(W);
    localparam int NF   = qftv_pkg::UNIT_FRAC;
    localparam int NM_W = qftv_pkg::NM_W;
    localparam int SQ_W = 2 * NM_W;
    localparam int SUM_W = qftv_pkg::SQRT_IN_W;
    localparam int DW   = qftv_pkg::DIV_W;
    localparam int UW   = qftv_pkg::UNIT_W;
    localparam int SH_W = W + NF;
    localparam int TU_W = TAG_W + 3 + 3 * NM_W;
    localparam int TV_W = 3 + 3 * NM_W;

    // ---------------- stage A: block normalize to [2^30, 2^31) ----------
    logic [W-1:0]                   comp [6];
    logic [W-1:0]                   mag  [6];
    logic [W-1:0]                   orv  [2];
    logic [PW-1:0]                  msb  [2];
    logic [SH_W-1:0]                wide [6];
    logic [1:0][2:0][NM_W-1:0]      nm_a;
    logic [1:0][2:0]                sgn_a;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp[i]     = in_u[i];
            comp[i + 3] = in_v[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            mag[i] = comp[i][W-1] ? (~comp[i] + 1'b1) : comp[i];
        end
        for (int k = 0; k < 2; k++)
        begin
            orv[k] = mag[3*k] | mag[3*k+1] | mag[3*k+2];
            msb[k] = '0;
            for (int b = 0; b < W; b++)
            begin
                if (orv[k][b])
                begin
                    msb[k] = PW'(b);
                end
            end
        end
        // Shifting by 30 and back by the leading bit position lands the
        // largest magnitude at bit 30 in either direction.
        for (int i = 0; i < 6; i++)
        begin
            wide[i]               = {mag[i], {NF{1'b0}}} >> msb[i / 3];
            nm_a[i / 3][i % 3]    = wide[i][NM_W-1:0];
            sgn_a[i / 3][i % 3]   = comp[i][W-1];
        end
    end

    logic                       vld_a_reg, vld_b_reg, vld_c_reg;
    logic [1:0][2:0][NM_W-1:0]  nm_a_reg, nm_b_reg, nm_c_reg;
    logic [1:0][2:0]            sgn_a_reg, sgn_b_reg, sgn_c_reg;
    logic [TAG_W-1:0]           tag_a_reg, tag_b_reg, tag_c_reg;
    logic [1:0][2:0][SQ_W-1:0]  sq_b_reg;
    logic [1:0][SUM_W-1:0]      sum_c_reg;

    // ---------------- stage B: squares, stage C: sums -------------------
    logic [1:0][2:0][SQ_W-1:0]  sq_next;
    logic [1:0][SUM_W-1:0]      sum_next;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_next[k][i] = nm_a_reg[k][i] * nm_a_reg[k][i];
            end
            sum_next[k] = SUM_W'(sq_b_reg[k][0]) + SUM_W'(sq_b_reg[k][1])
                        + SUM_W'(sq_b_reg[k][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_a_reg  <= nm_a;
            sgn_a_reg <= sgn_a;
            tag_a_reg <= in_tag;
            nm_b_reg  <= nm_a_reg;
            sgn_b_reg <= sgn_a_reg;
            tag_b_reg <= tag_a_reg;
            sq_b_reg  <= sq_next;
            nm_c_reg  <= nm_b_reg;
            sgn_c_reg <= sgn_b_reg;
            tag_c_reg <= tag_b_reg;
            sum_c_reg <= sum_next;
        end
    end

    // ---------------- lengths -------------------------------------------
    logic              vld_su, vld_sv;
    logic [DW-1:0]     len_u, len_v;
    logic [TU_W-1:0]   tag_su;
    logic [TV_W-1:0]   tag_sv;

    qftv_isqrt #(
        .IN_W  (SUM_W),
        .STEPS (qftv_pkg::SQRT_STEPS),
        .TAG_W (TU_W)
    ) u_sqrt_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_c_reg),
        .in_x     (sum_c_reg[0]),
        .in_tag   ({tag_c_reg, sgn_c_reg[0], nm_c_reg[0]}),
        .out_vld  (vld_su),
        .out_root (len_u),
        .out_tag  (tag_su)
    );

    qftv_isqrt #(
        .IN_W  (SUM_W),
        .STEPS (qftv_pkg::SQRT_STEPS),
        .TAG_W (TV_W)
    ) u_sqrt_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_c_reg),
        .in_x     (sum_c_reg[1]),
        .in_tag   ({sgn_c_reg[1], nm_c_reg[1]}),
        .out_vld  (vld_sv),
        .out_root (len_v),
        .out_tag  (tag_sv)
    );

    // ---------------- component / length --------------------------------
    // The quotient never exceeds 2^30, so its upper thirty bits are known
    // zero and division starts with the remainder at nm >> 1.
    logic [2:0][NM_W-1:0]  nm_u, nm_v;
    logic [2:0][DW-1:0]    rem_u, rem_v;
    logic [2:0][NM_W-1:0]  feed_u, feed_v;

    assign nm_u = tag_su[3*NM_W-1:0];
    assign nm_v = tag_sv[3*NM_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_u[i]  = DW'(nm_u[i][NM_W-1:1]);
            rem_v[i]  = DW'(nm_v[i][NM_W-1:1]);
            feed_u[i] = {nm_u[i][0], {NF{1'b0}}};
            feed_v[i] = {nm_v[i][0], {NF{1'b0}}};
        end
    end

    logic                      vld_du, vld_dv;
    logic [2:0][NM_W-1:0]      quo_u, quo_v;
    logic [TAG_W+2:0]          tag_du;
    logic [2:0]                sgn_dv;

    qftv_div #(
        .LANES (3),
        .QW    (NM_W),
        .DW    (DW),
        .STEPS (qftv_pkg::DIV_STEPS),
        .TAG_W (TAG_W + 3)
    ) u_div_u (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_su & vld_sv),
        .in_rem  (rem_u),
        .in_feed (feed_u),
        .in_div  (len_u),
        .in_tag  (tag_su[TU_W-1:3*NM_W]),
        .out_vld (vld_du),
        .out_quo (quo_u),
        .out_tag (tag_du)
    );

    qftv_div #(
        .LANES (3),
        .QW    (NM_W),
        .DW    (DW),
        .STEPS (qftv_pkg::DIV_STEPS),
        .TAG_W (3)
    ) u_div_v (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_su & vld_sv),
        .in_rem  (rem_v),
        .in_feed (feed_v),
        .in_div  (len_v),
        .in_tag  (tag_sv[TV_W-1:3*NM_W]),
        .out_vld (vld_dv),
        .out_quo (quo_v),
        .out_tag (sgn_dv)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_uh[i] = tag_du[i] ? -$signed({1'b0, quo_u[i]}) : $signed({1'b0, quo_u[i]});
            out_vh[i] = sgn_dv[i] ? -$signed({1'b0, quo_v[i]}) : $signed({1'b0, quo_v[i]});
        end
    end

    assign out_vld = vld_du & vld_dv;
    assign out_tag = tag_du[TAG_W+2:3];

endmodule

`default_nettype wire

// ===== sim/quaternion_from_two_vectors_checker.sv =====
// ============================================================================
// quaternion_from_two_vectors_checker
// Watches both stream channels, predicts each quaternion and compares it.
// ============================================================================
`default_nettype none

module quaternion_from_two_vectors_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] qz;
        logic [15:0] qy;
        logic [15:0] qx;
        logic [15:0] qw;
    } quat_t;

    quat_t quat_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint magnitude(input longint a);
        return a < 0 ? -a : a;
    endfunction

    // Scales a nonzero vector to unit length in Q.30.
    function automatic void normalize3(input longint c[3], output longint h[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned acc;
        longint unsigned len;
        longint qv;
        mx = 0;
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = magnitude(c[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        while (mx < (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
            mx = mx << 1;
        end
        while (mx >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        for (int i = 0; i < 3; i++)
            acc += m[i] * m[i];
        len = int_sqrt(acc);
        for (int i = 0; i < 3; i++)
        begin
            qv = longint'((m[i] << 30) / len);
            h[i] = c[i] < 0 ? -qv : qv;
        end
    endfunction

    function automatic quat_t shortest_arc(input logic [95:0] d);
        longint u[3];
        longint v[3];
        longint uh[3];
        longint vh[3];
        longint q[4];
        longint unsigned m[4];
        longint unsigned mx;
        longint unsigned acc;
        longint unsigned nrm;
        longint unsigned r;
        longint dot;
        int k;
        quat_t res;
        res = '{status: qftv_pkg::STATUS_OK, qw: qftv_pkg::Q_ONE, qx: '0, qy: '0, qz: '0};
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'($signed(d[16*i +: 16]));
            v[i] = longint'($signed(d[16*(i+3) +: 16]));
        end
        if ((u[0] == 0 && u[1] == 0 && u[2] == 0) || (v[0] == 0 && v[1] == 0 && v[2] == 0))
        begin
            res.status = qftv_pkg::STATUS_ZERO_LEN;
            return res;
        end
        normalize3(u, uh);
        normalize3(v, vh);
        dot = uh[0] * vh[0] + uh[1] * vh[1] + uh[2] * vh[2];
        if (u[1] * v[2] == u[2] * v[1] && u[2] * v[0] == u[0] * v[2]
            && u[0] * v[1] == u[1] * v[0])
        begin
            res.status = dot < 0 ? qftv_pkg::STATUS_ANTIPARALLEL : qftv_pkg::STATUS_OK;
            return res;
        end
        q[0] = (64'sd1 <<< 60) + dot;
        if (q[0] < 0)
            q[0] = 0;
        q[1] = uh[1] * vh[2] - uh[2] * vh[1];
        q[2] = uh[2] * vh[0] - uh[0] * vh[2];
        q[3] = uh[0] * vh[1] - uh[1] * vh[0];
        mx = 0;
        acc = 0;
        k = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = magnitude(q[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        while ((mx >> k) >= (64'd1 << 30))
            k++;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = m[i] >> k;
            acc += m[i] * m[i];
        end
        nrm = int_sqrt(acc);
        if (nrm == 0)
        begin
            res.status = qftv_pkg::STATUS_ANTIPARALLEL;
            return res;
        end
        for (int i = 0; i < 4; i++)
        begin
            r = (m[i] * 16384 + nrm / 2) / nrm;
            if (r > 16384)
                r = 16384;
            q[i] = q[i] < 0 ? -longint'(r) : longint'(r);
        end
        res.qw = q[0][15:0];
        res.qx = q[1][15:0];
        res.qy = q[2][15:0];
        res.qz = q[3][15:0];
        return res;
    endfunction

    assign pending = quat_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        quat_t got;
        quat_t want;
        if (!rst_n)
        begin
            mismatches <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                quat_q.push_back(shortest_arc(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[65:0];
                if (quat_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected transaction: %h", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = quat_q.pop_front();
                    if (got !== want || m_tdata[71:66] !== 6'd0)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d st=%0d, got w=%0d x=%0d y=%0d z=%0d st=%0d",
                                     $signed(want.qw), $signed(want.qx), $signed(want.qy),
                                     $signed(want.qz), want.status, $signed(got.qw),
                                     $signed(got.qx), $signed(got.qy), $signed(got.qz),
                                     got.status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_quaternion_from_two_vectors_top.sv =====
// ============================================================================
// tb_quaternion_from_two_vectors_top
// Stimulus and verdict for the shortest-arc quaternion block.
// ============================================================================
// Directed vector pairs cover extremes, zero-length, parallel and antiparallel
// cases; random pairs follow in three flow-control phases. A separate checker
// predicts every result and counts mismatches.
`default_nettype none

module tb_quaternion_from_two_vectors_top;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    int          mismatches;
    int          pending;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          stall_count;

    quaternion_from_two_vectors_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    quaternion_from_two_vectors_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatches(mismatches), .pending(pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Ready toggles at random on the falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(6)) - 3);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // One pair sent; waits for the handshake, then the next falling edge.
    // Valid stays high into the next pair unless the sender idles.
    task automatic send_pair(input logic [15:0] c[6]);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c[5], c[4], c[3], c[2], c[1], c[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [15:0] c[6];
        int scale;
        for (int i = 0; i < 3; i++)
            c[i] = rand_comp();
        case ($urandom_range(9))
            0:
            begin
                // Parallel, antiparallel or zero: scale u by an integer from -2 to 2.
                scale = $urandom_range(4) - 2;
                for (int i = 0; i < 3; i++)
                    c[i + 3] = 16'($signed(c[i]) * scale);
            end
            1:
                for (int i = 0; i < 3; i++)
                    c[i + 3] = 16'(-$signed(c[i]));
            default:
                for (int i = 3; i < 6; i++)
                    c[i] = rand_comp();
        endcase
        send_pair(c);
    endtask

    initial
    begin
        logic [15:0] c[6];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        src_idle_pct = 17;
        snk_idle_pct = 50;
        stall_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        c = '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000};
        send_pair(c);
        c = '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        send_pair(c);
        c = '{16'h4000, 16'h0000, 16'h0000, 16'h2000, 16'h0000, 16'h0000};
        send_pair(c);
        c = '{16'h4000, 16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000};
        send_pair(c);
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff};
        send_pair(c);
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        send_pair(c);
        c = '{16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000};
        send_pair(c);
        c = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001};
        send_pair(c);
        c = '{16'h0001, 16'h0001, 16'h0001, 16'hffff, 16'hffff, 16'hffff};
        send_pair(c);
        c = '{16'h7fff, 16'h0001, 16'h0000, 16'h8000, 16'h0000, 16'h0000};
        send_pair(c);
        c = '{16'hffff, 16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff};
        send_pair(c);
        c = '{16'h5555, 16'haaaa, 16'h1234, 16'haaaa, 16'h5555, 16'hedcb};
        send_pair(c);

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 50 : 0;
            snk_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 17 : 0;
            for (int n = 0; n < 615; n++)
                send_random();
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
